FILE: src/mmsc_pkg.sv
`default_nettype none

package mmsc_pkg;

    // Default configuration of the block
    localparam int DEF_CHANNELS      = 64;
    localparam int DEF_FRACTION_BITS = 16;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int ACTION_W  = 3;
    localparam int CHANNEL_W = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Divider widths: magnitude dividend, magnitude divisor, quotient
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = DATA_W + 1;
    localparam int QUO_W      = DATA_W;

    // Table reset values
    localparam logic [DATA_W-1:0] MIN_RESET = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MAX_RESET = 32'h8000_0000;

    // Configuration reset values
    localparam logic [DATA_W-1:0] TARGET_MIN_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] TARGET_MAX_RESET = 32'h0001_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE = 2'd2;

    // Operation codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_GATHER      = 3'd0,
        ACT_NORMALIZE   = 3'd1,
        ACT_DENORMALIZE = 3'd2,
        ACT_LOAD_MIN    = 3'd3,
        ACT_LOAD_MAX    = 3'd4
    } action_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SPAN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

    // Divider status toward the sequencer
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

`default_nettype wire

FILE: src/mmsc_ram.sv
`default_nettype none

module mmsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/mmsc_div.sv
`default_nettype none

module mmsc_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [mmsc_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [mmsc_pkg::DIVISOR_W-1:0]  divisor,
    output mmsc_pkg::div_res_t                   res
);

    import mmsc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_ITER
    } dstate_t;

    dstate_t              state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [DIVISOR_W-1:0] den_reg;
    logic                 done_reg;
    logic                 ovf_reg;

    logic [DIVISOR_W:0]   trial_a;
    logic [DIVISOR_W+1:0] trial_d;
    logic                 trial_ge;

    // Shared trial subtract: overflow check first, then one quotient bit per cycle
    always_comb
    begin
        if (state_reg == D_CHECK)
        begin
            trial_a = {1'b0, rem_reg};
        end
        else
        begin
            trial_a = {rem_reg, low_reg[QUO_W-1]};
        end
        trial_d  = {1'b0, trial_a} - {2'b00, den_reg};
        trial_ge = !trial_d[DIVISOR_W+1];
    end

    // Sequencer and partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            low_reg   <= '0;
            den_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= {1'b0, dividend[DIVIDEND_W-1:QUO_W]};
                        low_reg   <= dividend[QUO_W-1:0];
                        den_reg   <= divisor;
                        ovf_reg   <= 1'b0;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    // high half not below divisor: quotient needs more than QUO_W bits
                    if (trial_ge)
                    begin
                        ovf_reg   <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= D_ITER;
                    end
                end
                D_ITER:
                begin
                    low_reg <= {low_reg[QUO_W-2:0], trial_ge};
                    if (trial_ge)
                    begin
                        rem_reg <= trial_d[DIVISOR_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= trial_a[DIVISOR_W-1:0];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = low_reg;

endmodule

`default_nettype wire

FILE: src/per_channel_min_max_scaler.sv
// Per-channel min/max feature scaler, signed fixed point (Q16.16 by default).
// Input channel: in_valid/in_stall with action, channel and sample. Gather
// widens the channel's [min, max], load min / load max write a bound, and
// normalize / denormalize produce one result on the output channel
// (out_valid/out_stall with scaled and status). Unknown actions are dropped.
// Configuration: cfg_write with cfg_index and cfg_data writes target_min,
// target_max or clamp_enable; write only while the block is idle.
// Steps: gather and load write the tables in a setup state. Normalize and
// denormalize pass through setup and prep, then the radix-2 divider (one
// overflow check plus 32 quotient bits, one per cycle), a 32x32 multiply,
// an add and the output load. A zero range skips the divider; a quotient
// that overflows in the check skips the quotient bits.
// One item is in work at a time; in_stall is high until it finishes. The
// result sits in an output register, so a new item is accepted while an
// earlier result still waits; a stalled receiver only holds the block once
// the next result is ready to load.
// Reset: min/max tables are cleared over all CHANNELS entries, one entry
// per cycle, with in_stall high; configuration takes writes throughout.
`default_nettype none

module per_channel_min_max_scaler #(
    parameter int CHANNELS      = mmsc_pkg::DEF_CHANNELS,
    parameter int FRACTION_BITS = mmsc_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [mmsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mmsc_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mmsc_pkg::ACTION_W-1:0]  action,
    input  wire logic [mmsc_pkg::CHANNEL_W-1:0] channel,
    input  wire logic signed [mmsc_pkg::DATA_W-1:0] sample,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [mmsc_pkg::DATA_W-1:0]  scaled,
    output logic [mmsc_pkg::STATUS_W-1:0]       status
);

    import mmsc_pkg::*;

    localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_SPAN = 1 << CHANNEL_W;
    localparam int WIDE_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int RES_W     = 60;
    localparam int TOP_W     = RES_W - DATA_W + 1;
    localparam logic [AW-1:0]     CLR_LAST = AW'(CHANNELS - 1);
    localparam logic [QUO_W-1:0]  Q_POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0]  Q_NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_PREP,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FINISH
    } state_t;

    // Control and configuration
    state_t                     state_reg;
    logic [AW-1:0]              clr_reg;
    logic signed [DATA_W-1:0]   tmin_reg;
    logic signed [DATA_W-1:0]   tmax_reg;
    logic                       clamp_reg;
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   scaled_reg;
    logic [STATUS_W-1:0]        status_reg;

    // Datapath
    logic [ACTION_W-1:0]        action_reg;
    logic [AW-1:0]              chan_reg;
    logic signed [DATA_W-1:0]   x_reg;
    logic signed [WIDE_W-1:0]   diff_reg;
    logic signed [WIDE_W-1:0]   den_reg;
    logic signed [WIDE_W-1:0]   span_reg;
    logic signed [DATA_W-1:0]   tolo_reg;
    logic                       qneg_reg;
    logic                       pneg_reg;
    logic [DATA_W-1:0]          span_mag_reg;
    logic [QUO_W-1:0]           qmag_reg;
    logic                       qsat_reg;
    logic                       zero_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [RES_W-1:0]           r_reg;

    logic                       in_accept;
    logic                       out_accept;
    logic                       out_free;
    logic                       out_load;

    logic [AW-1:0]              wrap_lut [CHAN_SPAN];
    logic [AW-1:0]              rd_addr;
    logic [DATA_W-1:0]          min_rdata;
    logic [DATA_W-1:0]          max_rdata;
    logic                       min_we;
    logic                       max_we;
    logic [AW-1:0]              wr_addr;
    logic [DATA_W-1:0]          min_wdata;
    logic [DATA_W-1:0]          max_wdata;

    logic signed [DATA_W-1:0]   mn;
    logic signed [DATA_W-1:0]   mx;
    logic signed [DATA_W-1:0]   xc;
    logic signed [DATA_W-1:0]   v_s;
    logic signed [DATA_W-1:0]   flo_s;
    logic signed [DATA_W-1:0]   fhi_s;
    logic signed [DATA_W-1:0]   tlo_s;
    logic signed [DATA_W-1:0]   thi_s;

    logic [WIDE_W-1:0]          diff_mag;
    logic [WIDE_W-1:0]          den_mag;
    logic [WIDE_W-1:0]          span_mag;
    logic [DIVIDEND_W-1:0]      dividend;
    logic                       div_start;
    div_res_t                   div_res;

    logic [RES_W-1:0]           prod_shift;
    logic [RES_W-1:0]           tolo_ext;
    logic                       r_in_range;
    logic signed [DATA_W-1:0]   r_sat;
    logic signed [DATA_W-1:0]   res_scaled;
    logic [STATUS_W-1:0]        res_status;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = (state_reg == S_FINISH) && out_free;

    // Channel wrap table, folded at elaboration
    for (genvar i = 0; i < CHAN_SPAN; i++)
    begin : g_wrap
        assign wrap_lut[i] = AW'(i % CHANNELS);
    end

    assign rd_addr = wrap_lut[channel];

    // Min and max tables
    mmsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHANNELS)
    ) u_min_ram (
        .clk   (clk),
        .we    (min_we),
        .waddr (wr_addr),
        .wdata (min_wdata),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (min_rdata)
    );

    mmsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHANNELS)
    ) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .waddr (wr_addr),
        .wdata (max_wdata),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (max_rdata)
    );

    // Select map operands; clamp limits to target_max first, then target_min
    always_comb
    begin
        mn = $signed(min_rdata);
        mx = $signed(max_rdata);
        xc = x_reg;
        if (clamp_reg)
        begin
            if (xc > tmax_reg)
            begin
                xc = tmax_reg;
            end
            if (xc < tmin_reg)
            begin
                xc = tmin_reg;
            end
        end
        if (action_reg == ACT_NORMALIZE)
        begin
            v_s   = x_reg;
            flo_s = mn;
            fhi_s = mx;
            tlo_s = tmin_reg;
            thi_s = tmax_reg;
        end
        else
        begin
            v_s   = xc;
            flo_s = tmin_reg;
            fhi_s = tmax_reg;
            tlo_s = mn;
            thi_s = mx;
        end
    end

    // Table writes: clearing pass, gather and loads
    always_comb
    begin
        min_we    = 1'b0;
        max_we    = 1'b0;
        wr_addr   = chan_reg;
        min_wdata = x_reg;
        max_wdata = x_reg;
        if (state_reg == S_CLEAR)
        begin
            min_we    = 1'b1;
            max_we    = 1'b1;
            wr_addr   = clr_reg;
            min_wdata = MIN_RESET;
            max_wdata = MAX_RESET;
        end
        else if (state_reg == S_SETUP)
        begin
            case (action_reg)
                ACT_GATHER:
                begin
                    min_we = 1'b1;
                    max_we = 1'b1;
                    if (mn < x_reg)
                    begin
                        min_wdata = mn;
                    end
                    if (mx > x_reg)
                    begin
                        max_wdata = mx;
                    end
                end
                ACT_LOAD_MIN:
                begin
                    min_we = 1'b1;
                end
                ACT_LOAD_MAX:
                begin
                    max_we = 1'b1;
                end
                default:
                begin
                    min_we = 1'b0;
                    max_we = 1'b0;
                end
            endcase
        end
    end

    // Magnitudes for the divider and the multiplier
    always_comb
    begin
        diff_mag  = diff_reg[WIDE_W-1] ? WIDE_W'(-diff_reg) : WIDE_W'(diff_reg);
        den_mag   = den_reg[WIDE_W-1] ? WIDE_W'(-den_reg) : WIDE_W'(den_reg);
        span_mag  = span_reg[WIDE_W-1] ? WIDE_W'(-span_reg) : WIDE_W'(span_reg);
        dividend  = DIVIDEND_W'(diff_mag) << FRACTION_BITS;
        div_start = (state_reg == S_PREP) && (den_reg != '0);
    end

    mmsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_mag),
        .res      (div_res)
    );

    // Scale back, add the offset and saturate
    always_comb
    begin
        prod_shift = RES_W'(prod_reg >> FRACTION_BITS);
        tolo_ext   = {{(RES_W-DATA_W){tolo_reg[DATA_W-1]}}, tolo_reg};
        r_in_range = (r_reg[RES_W-1:DATA_W-1] == {TOP_W{1'b0}})
                  || (r_reg[RES_W-1:DATA_W-1] == {TOP_W{1'b1}});
        if (r_in_range)
        begin
            r_sat = $signed(r_reg[DATA_W-1:0]);
        end
        else if (r_reg[RES_W-1])
        begin
            r_sat = $signed(Q_NEG_MAX);
        end
        else
        begin
            r_sat = $signed(Q_POS_MAX);
        end
        if (zero_reg)
        begin
            res_scaled = tmin_reg;
            res_status = ST_ZERO_SPAN;
        end
        else
        begin
            res_scaled = r_sat;
            res_status = (qsat_reg || !r_in_range) ? ST_SATURATED : ST_OK;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmin_reg  <= TARGET_MIN_RESET;
            tmax_reg  <= TARGET_MAX_RESET;
            clamp_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_MIN:   tmin_reg  <= cfg_data;
                REG_TARGET_MAX:   tmax_reg  <= cfg_data;
                REG_CLAMP_ENABLE: clamp_reg <= cfg_data[0];
                default:          clamp_reg <= clamp_reg;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            scaled_reg    <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            // Load a new result or drop the one just transferred
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    if (action_reg == ACT_NORMALIZE || action_reg == ACT_DENORMALIZE)
                    begin
                        state_reg <= S_PREP;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PREP:
                begin
                    state_reg <= (den_reg == '0) ? S_FINISH : S_DIV;
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold the result until the output register is free
                    if (out_load)
                    begin
                        scaled_reg    <= res_scaled;
                        status_reg    <= res_status;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            chan_reg   <= rd_addr;
            x_reg      <= sample;
        end
        if (state_reg == S_SETUP)
        begin
            diff_reg <= {v_s[DATA_W-1], v_s} - {flo_s[DATA_W-1], flo_s};
            den_reg  <= {fhi_s[DATA_W-1], fhi_s} - {flo_s[DATA_W-1], flo_s};
            span_reg <= {thi_s[DATA_W-1], thi_s} - {tlo_s[DATA_W-1], tlo_s};
            tolo_reg <= tlo_s;
        end
        if (state_reg == S_PREP)
        begin
            zero_reg     <= (den_reg == '0);
            qneg_reg     <= diff_reg[WIDE_W-1] ^ den_reg[WIDE_W-1];
            pneg_reg     <= diff_reg[WIDE_W-1] ^ den_reg[WIDE_W-1] ^ span_reg[WIDE_W-1];
            span_mag_reg <= span_mag[DATA_W-1:0];
        end
        // Saturate the quotient to the signed 32-bit range
        if (state_reg == S_DIV && div_res.done)
        begin
            if (div_res.ovf || (!qneg_reg && div_res.quo > Q_POS_MAX)
                || (qneg_reg && div_res.quo > Q_NEG_MAX))
            begin
                qsat_reg <= 1'b1;
                qmag_reg <= qneg_reg ? Q_NEG_MAX : Q_POS_MAX;
            end
            else
            begin
                qsat_reg <= 1'b0;
                qmag_reg <= div_res.quo;
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= qmag_reg * span_mag_reg;
        end
        if (state_reg == S_ADD)
        begin
            r_reg <= pneg_reg ? (tolo_ext - prod_shift) : (tolo_ext + prod_shift);
        end
    end

    assign out_valid = out_valid_reg;
    assign scaled    = scaled_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mmsc_pkg::*;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     SETTLE_CYCLES = 60;
    localparam longint UNIT          = 64'sd1 << DEF_FRACTION_BITS;
    localparam longint S32_TOP       = 64'sd2147483647;
    localparam longint S32_BOTTOM    = -64'sd2147483648;

    // Action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      code;
    } scaled_t;

    // Channel bound tables, target range and the queue of scaled values due
    class scaler_board;
        logic signed [DATA_W-1:0] lo_bound [DEF_CHANNELS];
        logic signed [DATA_W-1:0] hi_bound [DEF_CHANNELS];
        logic signed [DATA_W-1:0] tgt_lo;
        logic signed [DATA_W-1:0] tgt_hi;
        bit                       clamp_on;
        scaled_t                  results_due [$];
        int                       errors;

        function new();
            foreach (lo_bound[i])
            begin
                lo_bound[i] = MIN_RESET;
                hi_bound[i] = MAX_RESET;
            end
            tgt_lo   = TARGET_MIN_RESET;
            tgt_hi   = TARGET_MAX_RESET;
            clamp_on = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_TARGET_MIN:   tgt_lo = data;
                REG_TARGET_MAX:   tgt_hi = data;
                REG_CLAMP_ENABLE: clamp_on = data[0];
                default: ;
            endcase
        endfunction

        // Map v from one span onto another; every division truncates toward zero
        function scaled_t map_span(longint v, longint from_lo, longint from_hi,
                                   longint to_lo, longint to_hi);
            longint  den;
            longint  q;
            longint  r;
            scaled_t res;
            res.code = ST_OK;
            den = from_hi - from_lo;
            if (den == 0)
            begin
                res.value = tgt_lo;
                res.code  = ST_ZERO_SPAN;
                return res;
            end
            q = ((v - from_lo) * UNIT) / den;
            if (q > S32_TOP)
            begin
                q = S32_TOP;
                res.code = ST_SATURATED;
            end
            else if (q < S32_BOTTOM)
            begin
                q = S32_BOTTOM;
                res.code = ST_SATURATED;
            end
            r = (q * (to_hi - to_lo)) / UNIT + to_lo;
            if (r > S32_TOP)
            begin
                r = S32_TOP;
                res.code = ST_SATURATED;
            end
            else if (r < S32_BOTTOM)
            begin
                r = S32_BOTTOM;
                res.code = ST_SATURATED;
            end
            res.value = r[DATA_W-1:0];
            return res;
        endfunction

        // Update the tables for one accepted transfer and queue its result
        function void note_input(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
                                 logic signed [DATA_W-1:0] x);
            int     idx;
            longint v;
            idx = ch % DEF_CHANNELS;
            v   = x;
            case (act)
                ACT_GATHER:
                begin
                    if (x < lo_bound[idx])
                        lo_bound[idx] = x;
                    if (x > hi_bound[idx])
                        hi_bound[idx] = x;
                end
                ACT_NORMALIZE:
                    results_due.push_back(map_span(v, lo_bound[idx], hi_bound[idx],
                                                   tgt_lo, tgt_hi));
                ACT_DENORMALIZE:
                begin
                    // Limit to the top first, then to the bottom
                    if (clamp_on)
                    begin
                        if (v > tgt_hi)
                            v = tgt_hi;
                        if (v < tgt_lo)
                            v = tgt_lo;
                    end
                    results_due.push_back(map_span(v, tgt_lo, tgt_hi,
                                                   lo_bound[idx], hi_bound[idx]));
                end
                ACT_LOAD_MIN: lo_bound[idx] = x;
                ACT_LOAD_MAX: hi_bound[idx] = x;
                default: ;
            endcase
        endfunction

        // Compare one output transfer against the oldest queued result
        function void check_result(logic signed [DATA_W-1:0] got_value,
                                   logic [STATUS_W-1:0] got_code);
            scaled_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got scaled %h status %0d",
                         $time, got_value, got_code);
                return;
            end
            want = results_due.pop_front();
            if (got_value !== want.value)
            begin
                errors++;
                $display("%0t: scaled mismatch, expected %h, got %h",
                         $time, want.value, got_value);
            end
            if (got_code !== want.code)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.code, got_code);
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [DATA_W-1:0]           cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [ACTION_W-1:0]         action;
    logic [CHANNEL_W-1:0]        channel;
    logic signed [DATA_W-1:0]    sample;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    scaled;
    logic [STATUS_W-1:0]         status;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count;
    scaler_board sb = new();

    per_channel_min_max_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .channel   (channel),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scaled    (scaled),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Stall the output channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Observe transfers: results first, then register writes, then inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(scaled, status);
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_input(action, channel, sample);
        end
    end

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Write all three registers on back-to-back cycles
    task automatic apply_targets(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                                 input bit clamp);
        cfg_write <= 1'b1;
        cfg_index <= REG_TARGET_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_TARGET_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_CLAMP_ENABLE;
        cfg_data  <= {{(DATA_W-1){1'b0}}, clamp};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Present one item, with a random gap ahead, and hold it until the transfer
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CHANNEL_W-1:0] ch,
                             input logic [DATA_W-1:0] x);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        action   <= act;
        channel  <= ch;
        sample   <= x;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Drain, then let a gather or load still in work finish
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            4:       return $urandom_range(255);
            default: return $urandom_range(32'h20_0000) - 32'h10_0000;
        endcase
    endfunction

    // Half the time any value, else mostly inside the target range, a little past each end
    function automatic logic [DATA_W-1:0] pick_target_value();
        longint span;
        longint v;
        span = longint'(sb.tgt_hi) - longint'(sb.tgt_lo);
        if ($urandom_range(1) == 0)
            return pick_value();
        v = longint'(sb.tgt_lo) + (span * longint'($urandom_range(1100))) / 1000 - span / 20;
        return v[DATA_W-1:0];
    endfunction

    task automatic run_random(input int count, input bit pause_midway);
        int                  done_items;
        int                  roll;
        logic [ACTION_W-1:0] act;
        logic [CHANNEL_W-1:0] ch;
        logic [DATA_W-1:0]   x;
        done_items = 0;
        while (done_items < count)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                act = ACT_GATHER;
            else if (roll < 55)
                act = ACT_NORMALIZE;
            else if (roll < 80)
                act = ACT_DENORMALIZE;
            else if (roll < 87)
                act = ACT_LOAD_MIN;
            else if (roll < 94)
                act = ACT_LOAD_MAX;
            else
                act = $urandom_range(ACT_SPARE_HI, ACT_SPARE_LO);
            // Keep most traffic on a few channels so their bounds fill in
            ch = ($urandom_range(3) == 0) ? $urandom_range(DEF_CHANNELS - 1)
                                          : $urandom_range(7);
            x = (act == ACT_DENORMALIZE) ? pick_target_value() : pick_value();
            send_item(act, ch, x);
            if (act <= ACT_LOAD_MAX)
                done_items++;
            if (pause_midway && done_items == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= '0;
        channel   <= '0;
        sample    <= '0;
        out_stall <= 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 45;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unset bounds, full-scale bounds, zero span, overflows
        send_item(ACT_NORMALIZE, 6'd0, 32'h0000_0000);
        send_item(ACT_DENORMALIZE, 6'd1, 32'h0000_8000);
        send_item(ACT_GATHER, 6'd2, 32'h7FFF_FFFF);
        send_item(ACT_GATHER, 6'd2, 32'h8000_0000);
        send_item(ACT_NORMALIZE, 6'd2, 32'h0000_0000);
        send_item(ACT_NORMALIZE, 6'd2, 32'h7FFF_FFFF);
        send_item(ACT_NORMALIZE, 6'd2, 32'h8000_0000);
        send_item(ACT_DENORMALIZE, 6'd2, 32'h0002_0000);
        send_item(ACT_LOAD_MIN, 6'd3, 32'h0000_0005);
        send_item(ACT_LOAD_MAX, 6'd3, 32'h0000_0005);
        send_item(ACT_NORMALIZE, 6'd3, 32'h0001_2345);
        send_item(ACT_LOAD_MIN, 6'd6, 32'h0000_0000);
        send_item(ACT_LOAD_MAX, 6'd6, 32'h0000_0001);
        send_item(ACT_NORMALIZE, 6'd6, 32'h7FFF_FFFF);
        send_item(ACT_LOAD_MIN, 6'd4, 32'h0064_0000);
        send_item(ACT_LOAD_MAX, 6'd4, 32'hFF9C_0000);
        send_item(ACT_NORMALIZE, 6'd4, 32'h0000_0000);
        send_item(ACT_DENORMALIZE, 6'd4, 32'hFFFF_0000);
        send_item(ACT_GATHER, 6'd63, 32'h1234_5678);
        send_item(ACT_NORMALIZE, 6'd63, 32'h1234_5678);
        send_item(ACT_DENORMALIZE, 6'd63, 32'h0000_4000);
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_item(a[ACTION_W-1:0], 6'd63, 32'hFFFF_FFFF);
        send_item(ACT_NORMALIZE, 6'd63, 32'h0000_0000);
        settle();

        // Random phases over several target ranges and idle patterns
        for (int b = 0; b < 6; b++)
        begin
            if (b < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 45;
            end
            else if (b < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (b)
                0: apply_targets(32'h0000_0000, 32'h0001_0000, 1'b0);
                1: apply_targets(32'hFFFC_0000, 32'h0004_0000, 1'b1);
                2: apply_targets(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
                3: apply_targets(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
                4: apply_targets($urandom, $urandom, $urandom_range(1));
                default: apply_targets(32'h0005_0000, 32'h0005_0000, 1'b0);
            endcase
            run_random(135, b == 3);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
